[rtl/ufbd_pkg.sv]
// ----------------------------------------------------------------------------
// ufbd_pkg
// Shared types, constants and helpers for the fractional baud divider search.
// ----------------------------------------------------------------------------
`default_nettype none

package ufbd_pkg;

    localparam logic [21:0] CLK_RATE     = 22'd3000000;
    localparam logic [24:0] CLK_RATE_X10 = 25'd30000000;
    localparam logic [19:0] SPEED_MIN    = 20'd100;
    localparam logic [19:0] SPEED_MAX    = 20'd62500;
    localparam logic [15:0] SPEED_DFLT   = 16'd9600;
    localparam logic [4:0]  PARITY_ODD   = 5'h08;
    localparam logic [4:0]  PARITY_EVEN  = 5'h18;
    localparam logic [4:0]  Q_FIRST      = 5'd11;
    localparam logic [4:0]  Q_LAST       = 5'd19;
    localparam logic [3:0]  NUM_LAST     = 4'd14;
    localparam logic [3:0]  DEN_LAST     = 4'd15;
    localparam logic [3:0]  DIV_STEPS_M1 = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV0,
        ST_CHK0,
        ST_TMUL,
        ST_DIVT,
        ST_BMUL,
        ST_TCHK,
        ST_SRCH,
        ST_FLUSH,
        ST_OUT
    } ufbd_state_t;

    // Line control bits: word length code/6, stop bit code%2, parity (code/2)%3.
    function automatic logic [4:0] frame_bits(input logic [4:0] code);
        logic [4:0] wlen;
        logic [3:0] x;
        logic [4:0] par;
        if (code >= 5'd30)
            wlen = 5'd5;
        else if (code >= 5'd24)
            wlen = 5'd4;
        else if (code >= 5'd18)
            wlen = 5'd3;
        else if (code >= 5'd12)
            wlen = 5'd2;
        else if (code >= 5'd6)
            wlen = 5'd1;
        else
            wlen = 5'd0;
        x = code[4:1];
        if (x >= 4'd12)
            x = x - 4'd12;
        if (x >= 4'd6)
            x = x - 4'd6;
        if (x >= 4'd3)
            x = x - 4'd3;
        if (x == 4'd1)
            par = PARITY_ODD;
        else if (x == 4'd2)
            par = PARITY_EVEN;
        else
            par = 5'd0;
        return wlen + {2'b00, code[0], 2'b00} + par;
    endfunction

endpackage

`default_nettype wire

[rtl/uart_fractional_baud_divider.sv]
// ----------------------------------------------------------------------------
// uart_fractional_baud_divider
// Works out the UART divisor bytes and the fractional divider pair for a
// requested line speed, using one shared divide step and a small sequencer.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  req     | req_valid/req_ready  | baud_rate, frame_format
//  res     | res_valid/res_ready  | format_bits, divisor_low/high, add_value,
//          |                      | mul_value, fraction_written, speed_defaulted
//
// One request at a time; req_ready is high only while the sequencer is idle.
// An exact divisor skips the search; otherwise 1..9 pre-scale steps are
// tried, stopping at the first that puts the residual ratio in range or at
// 1.9, then the 210-candidate fraction search runs. The restoring divider
// takes one quotient bit per cycle, 11 bits.
// A stalled result holds in the output register while the next request is
// accepted. Reset (rst_n, asynchronous) returns the sequencer to idle.
`default_nettype none

module uart_fractional_baud_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [19:0] baud_rate,
    input  wire logic [4:0]  frame_format,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [4:0]       format_bits,
    output logic [7:0]       divisor_low,
    output logic [7:0]       divisor_high,
    output logic [3:0]       add_value,
    output logic [3:0]       mul_value,
    output logic             fraction_written,
    output logic             speed_defaulted
);

    import ufbd_pkg::*;

    ufbd_state_t state_reg, state_next;

    // Control registers
    logic [3:0]  cnt_reg, cnt_next;
    logic [4:0]  t_reg, t_next;
    logic [3:0]  num_reg, num_next;
    logic [3:0]  den_reg, den_next;
    logic        p_valid_reg, p_valid_next;
    logic        have_reg, have_next;
    logic        res_valid_reg, res_valid_next;

    // Datapath registers
    logic [19:0] over_reg, over_next;
    logic [24:0] rem_reg, rem_next;
    logic [34:0] dsh_reg, dsh_next;
    logic [10:0] quo_reg, quo_next;
    logic [10:0] div_reg, div_next;
    logic [21:0] b_reg, b_next;
    logic [25:0] bden_reg, bden_next;
    logic [25:0] bnum_reg, bnum_next;
    logic [25:0] cden_reg, cden_next;
    logic [26:0] e_reg, e_next;
    logic [26:0] bd2_reg, bd2_next;
    logic [3:0]  p_den_reg, p_den_next;
    logic [3:0]  p_num_reg, p_num_next;
    logic [26:0] best_e_reg, best_e_next;
    logic [3:0]  best_d_reg, best_d_next;
    logic [3:0]  add_reg, add_next;
    logic [3:0]  mul_reg, mul_next;
    logic [4:0]  fmt_reg, fmt_next;
    logic        dflt_reg, dflt_next;

    // Output registers
    logic [4:0]  fmt_o_reg, fmt_o_next;
    logic [10:0] div_o_reg, div_o_next;
    logic [3:0]  add_o_reg, add_o_next;
    logic [3:0]  mul_o_reg, mul_o_next;
    logic        frac_o_reg, frac_o_next;
    logic        dflt_o_reg, dflt_o_next;

    logic        accept;
    logic        speed_ok;
    logic [15:0] speed;
    logic        div_ge;
    logic        div_last;
    logic [24:0] over_t;
    logic [30:0] over_q;
    logic [26:0] b19;
    logic [26:0] b11;
    logic        q_hit;
    logic [26:0] cand_sum;
    logic [26:0] cden_ext;
    logic [30:0] lhs;
    logic [30:0] rhs;
    logic        better;
    logic        out_free;

    assign accept   = req_valid && req_ready;
    assign speed_ok = (baud_rate >= SPEED_MIN) && (baud_rate <= SPEED_MAX);
    assign speed    = speed_ok ? baud_rate[15:0] : SPEED_DFLT;
    assign div_ge   = {10'd0, rem_reg} >= dsh_reg;
    assign div_last = (cnt_reg == DIV_STEPS_M1);
    assign over_t   = over_reg * t_reg;
    assign over_q   = over_reg * quo_reg;
    assign b19      = 27'(b_reg) * 27'd19;
    assign b11      = 27'(b_reg) * 27'd11;
    // Residual ratio strictly inside (1.1, 1.9), compared without division.
    assign q_hit    = ({2'b00, CLK_RATE_X10} < b19) && ({2'b00, CLK_RATE_X10} > b11);
    assign cand_sum = {1'b0, bden_reg} + {1'b0, bnum_reg};
    assign cden_ext = {1'b0, cden_reg};
    assign lhs      = e_reg * best_d_reg;
    assign rhs      = best_e_reg * p_den_reg;
    assign better   = have_reg ? (lhs < rhs) : (e_reg < bd2_reg);
    assign out_free = !res_valid_reg || res_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV0;
            end
            ST_DIV0:
            begin
                if (div_last)
                    state_next = ST_CHK0;
            end
            ST_CHK0:
            begin
                state_next = (rem_reg == 25'd0) ? ST_OUT : ST_TMUL;
            end
            ST_TMUL:  state_next = ST_DIVT;
            ST_DIVT:
            begin
                if (div_last)
                    state_next = ST_BMUL;
            end
            ST_BMUL:  state_next = ST_TCHK;
            ST_TCHK:
            begin
                state_next = (q_hit || (t_reg == Q_LAST)) ? ST_SRCH : ST_TMUL;
            end
            ST_SRCH:
            begin
                if ((num_reg == NUM_LAST) && (den_reg == DEN_LAST))
                    state_next = ST_FLUSH;
            end
            ST_FLUSH: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        t_next         = t_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        p_valid_next   = 1'b0;
        have_next      = have_reg;
        res_valid_next = res_valid_reg;
        over_next      = over_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        b_next         = b_reg;
        bden_next      = bden_reg;
        bnum_next      = bnum_reg;
        cden_next      = cden_reg;
        e_next         = e_reg;
        bd2_next       = bd2_reg;
        p_den_next     = p_den_reg;
        p_num_next     = p_num_reg;
        best_e_next    = best_e_reg;
        best_d_next    = best_d_reg;
        add_next       = add_reg;
        mul_next       = mul_reg;
        fmt_next       = fmt_reg;
        dflt_next      = dflt_reg;
        fmt_o_next     = fmt_o_reg;
        div_o_next     = div_o_reg;
        add_o_next     = add_o_reg;
        mul_o_next     = mul_o_reg;
        frac_o_next    = frac_o_reg;
        dflt_o_next    = dflt_o_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        // The candidate compare runs in the cycle after candidate generation.
        if (p_valid_reg && better)
        begin
            have_next   = 1'b1;
            best_e_next = e_reg;
            best_d_next = p_den_reg;
            add_next    = p_num_reg;
            mul_next    = p_den_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    over_next = {speed, 4'd0};
                    rem_next  = {3'd0, CLK_RATE};
                    // The divisor starts at 16*speed shifted up by ten bits.
                    dsh_next  = {5'd0, speed, 14'd0};
                    quo_next  = 11'd0;
                    cnt_next  = 4'd0;
                    have_next = 1'b0;
                    add_next  = 4'd0;
                    mul_next  = 4'd0;
                    fmt_next  = frame_bits(frame_format);
                    dflt_next = !speed_ok;
                end
            end
            ST_DIV0, ST_DIVT:
            begin
                if (div_ge)
                    rem_next = rem_reg - dsh_reg[24:0];
                quo_next = {quo_reg[9:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 4'd1;
            end
            ST_CHK0:
            begin
                div_next = quo_reg;
                t_next   = Q_FIRST;
            end
            ST_TMUL:
            begin
                rem_next = CLK_RATE_X10;
                dsh_next = {over_t, 10'd0};
                quo_next = 11'd0;
                cnt_next = 4'd0;
            end
            ST_BMUL:
            begin
                div_next = quo_reg;
                b_next   = over_q[21:0];
            end
            ST_TCHK:
            begin
                t_next    = t_reg + 5'd1;
                num_next  = 4'd1;
                den_next  = 4'd1;
                bden_next = {4'd0, b_reg};
                bnum_next = {4'd0, b_reg};
                cden_next = {4'd0, CLK_RATE};
            end
            ST_SRCH:
            begin
                e_next       = (cden_ext > cand_sum) ? (cden_ext - cand_sum)
                                                     : (cand_sum - cden_ext);
                bd2_next     = {bden_reg, 1'b0};
                p_den_next   = den_reg;
                p_num_next   = num_reg;
                p_valid_next = 1'b1;
                if (den_reg == DEN_LAST)
                begin
                    den_next  = 4'd1;
                    bden_next = {4'd0, b_reg};
                    cden_next = {4'd0, CLK_RATE};
                    num_next  = num_reg + 4'd1;
                    bnum_next = bnum_reg + {4'd0, b_reg};
                end
                else
                begin
                    den_next  = den_reg + 4'd1;
                    bden_next = bden_reg + {4'd0, b_reg};
                    cden_next = cden_reg + {4'd0, CLK_RATE};
                end
            end
            ST_FLUSH:
            begin
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    fmt_o_next     = fmt_reg;
                    div_o_next     = div_reg;
                    add_o_next     = have_reg ? add_reg : 4'd0;
                    mul_o_next     = have_reg ? mul_reg : 4'd0;
                    frac_o_next    = have_reg;
                    dflt_o_next    = dflt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 4'd0;
            t_reg         <= Q_FIRST;
            num_reg       <= 4'd1;
            den_reg       <= 4'd1;
            p_valid_reg   <= 1'b0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            t_reg         <= t_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            p_valid_reg   <= p_valid_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        over_reg   <= over_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        b_reg      <= b_next;
        bden_reg   <= bden_next;
        bnum_reg   <= bnum_next;
        cden_reg   <= cden_next;
        e_reg      <= e_next;
        bd2_reg    <= bd2_next;
        p_den_reg  <= p_den_next;
        p_num_reg  <= p_num_next;
        best_e_reg <= best_e_next;
        best_d_reg <= best_d_next;
        add_reg    <= add_next;
        mul_reg    <= mul_next;
        fmt_reg    <= fmt_next;
        dflt_reg   <= dflt_next;
        fmt_o_reg  <= fmt_o_next;
        div_o_reg  <= div_o_next;
        add_o_reg  <= add_o_next;
        mul_o_reg  <= mul_o_next;
        frac_o_reg <= frac_o_next;
        dflt_o_reg <= dflt_o_next;
    end

    assign req_ready        = (state_reg == ST_IDLE);
    assign res_valid        = res_valid_reg;
    assign format_bits      = fmt_o_reg;
    assign divisor_low      = div_o_reg[7:0];
    assign divisor_high     = {5'd0, div_o_reg[10:8]};
    assign add_value        = add_o_reg;
    assign mul_value        = mul_o_reg;
    assign fraction_written = frac_o_reg;
    assign speed_defaulted  = dflt_o_reg;

    // A new result is only loaded from the hand-off state.
    a_res_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the hand-off state");

    // A fraction, when written, always has a non-zero pair.
    a_frac_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && frac_o_reg) |-> (add_o_reg != 4'd0) && (mul_o_reg != 4'd0))
        else $error("fraction written with a zero term");

    // The pre-scale step stays within 1.1 .. 1.9 while it is in use.
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TMUL || state_reg == ST_DIVT || state_reg == ST_TCHK)
        |-> (t_reg >= Q_FIRST) && (t_reg <= Q_LAST))
        else $error("pre-scale step out of range");

    // Candidate generation only visits DEN 1..15 and NUM 1..14.
    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> (den_reg != 4'd0) && (num_reg != 4'd0)
        && (num_reg <= NUM_LAST))
        else $error("search candidate out of range");

    // The pipelined compare is live only straight after a search cycle.
    a_pipe_valid: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg) == ST_SRCH)
        else $error("compare stage valid without a candidate");

endmodule

`default_nettype wire
